// ----- rtl/ate_pkg.sv -----
package ate_pkg;

	localparam int LINE_COLS   = 80;
	localparam int STORE_LINES = 128;
	localparam int SCREEN_ROWS = 25;
	localparam int PENDING_MAX = 256;

	localparam int SCR_ROWS  = (SCREEN_ROWS < STORE_LINES) ? SCREEN_ROWS : STORE_LINES;
	localparam int ROW_W     = $clog2(STORE_LINES);
	localparam int COL_W     = $clog2(LINE_COLS + 1);
	localparam int TOT_W     = $clog2(STORE_LINES + 1);
	localparam int PEND_W    = $clog2(PENDING_MAX);
	localparam int LDEPTH    = STORE_LINES * LINE_COLS;
	localparam int LADDR_W   = $clog2(LDEPTH);
	localparam int CLR_CELLS = SCR_ROWS * LINE_COLS;
	localparam int CLR_W     = (CLR_CELLS > 1) ? $clog2(CLR_CELLS) : 1;
	localparam int CELL_W    = 16;

	localparam logic [15:0] NUM_MAX = 16'hFFFF;

	// request kinds
	localparam logic [1:0] REQ_BYTE  = 2'd0;
	localparam logic [1:0] REQ_FLUSH = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// character codes
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UH    = 8'h48;
	localparam logic [7:0] CH_LF_F  = 8'h66;
	localparam logic [7:0] CH_UJ    = 8'h4A;
	localparam logic [7:0] CH_UK    = 8'h4B;
	localparam logic [7:0] CH_LM    = 8'h6D;

	// config register indexes
	localparam logic REG_DEFAULT_COLOR = 1'b0;
	localparam logic REG_CLEAR_COLOR   = 1'b1;

	localparam logic [2:0] ANSI_TO_VGA [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

	// one sgr code applied to an attribute
	function automatic logic [7:0] sgr_apply(input logic [7:0] attr, input logic [15:0] v,
		input logic [7:0] dflt);
		logic [7:0] r;
		r = attr;
		if (v == 16'd0) r = dflt;
		else if (v == 16'd1) r = attr | 8'h08;
		else if (v == 16'd7) r = {attr[3:0], attr[7:4]};
		else if (v >= 16'd30 && v <= 16'd37) r = {attr[7:4], 1'b0, ANSI_TO_VGA[v[2:0] - 3'd6]};
		else if (v >= 16'd90 && v <= 16'd97) r = {attr[7:4], 1'b1, ANSI_TO_VGA[v[2:0] - 3'd2]};
		else if (v >= 16'd40 && v <= 16'd47) r = {1'b0, ANSI_TO_VGA[v[2:0]], attr[3:0]};
		else if (v >= 16'd100 && v <= 16'd107) r = {1'b1, ANSI_TO_VGA[v[2:0] - 3'd4], attr[3:0]};
		return r;
	endfunction

	// logical line to physical ring line
	function automatic logic [ROW_W-1:0] phys_line(input logic [ROW_W-1:0] base,
		input logic [ROW_W-1:0] lg);
		logic [ROW_W:0] s;
		s = {1'b0, base} + {1'b0, lg};
		if (s >= (ROW_W+1)'(STORE_LINES)) s = s - (ROW_W+1)'(STORE_LINES);
		return s[ROW_W-1:0];
	endfunction

	function automatic logic [LADDR_W-1:0] line_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		return LADDR_W'(row) * LADDR_W'(LINE_COLS) + LADDR_W'(col);
	endfunction

endpackage

// ----- rtl/ate_ifs.sv -----
interface ate_req_if;
	import ate_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] char_code;
	logic [6:0] read_row;
	logic [6:0] read_col;
	modport source (output valid, req_type, char_code, read_row, read_col, input ready);
	modport sink (input valid, req_type, char_code, read_row, read_col, output ready);
endinterface

interface ate_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  cell_char;
	logic [7:0]  cell_color;
	logic        screen_on;
	logic [15:0] cursor_row;
	logic [15:0] cursor_col;
	logic [7:0]  lines_used;
	logic [7:0]  text_color;
	logic [7:0]  pending_count;
	modport source (output valid, cell_char, cell_color, screen_on, cursor_row, cursor_col,
		lines_used, text_color, pending_count, input ready);
	modport sink (input valid, cell_char, cell_color, screen_on, cursor_row, cursor_col,
		lines_used, text_color, pending_count, output ready);
endinterface

// ----- rtl/ate_ram.sv -----
module ate_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

// ----- rtl/ansi_terminal_text_engine.sv -----
// ANSI terminal text engine
// req_ch carries items: output bytes, end-of-command flushes and cell reads.
// rsp_ch returns one item per request: the read cell (zero unless a read of a
// row in use at a column below LINE_COLS) plus the cursor, mode, line count,
// color and pending length. The apb port writes default_color at 0x0 and
// clear_color at 0x4; the user must write them only while idle, which the
// block does not enforce. Plain bytes, flushes without a commit and unused
// types go from the idle state through the done state to the output register;
// a read also passes the read state. A newline or flush that commits a line
// walks LINE_COLS columns through the pending ram and line ram. A full screen
// clear writes SCR_ROWS * LINE_COLS cells, one per cycle; erase to end of line
// writes the remaining columns of one row, one per cycle. One item is worked
// on at a time. A finished result sits in an output register, so the next item
// is accepted while it waits; a stalled receiver holds the engine only when a
// second result is ready to be stored. Reset clears the parser, cursor and
// counts and loads the reset colors; the line and pending rams are not cleared.
module ansi_terminal_text_engine (
	input  logic        clk,
	input  logic        arst_n,
	ate_req_if.sink     req_ch,
	ate_rsp_if.source   rsp_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ate_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_COMMIT, ST_CLEAR, ST_ERASE, ST_DONE} state_t;
	typedef enum logic [1:0] {PH_TEXT, PH_ESC, PH_CSI} phase_t;

	state_t             state_q;
	phase_t             phase_q;
	logic [7:0]         dflt_q, clrc_q, attr_q;
	logic [ROW_W-1:0]   base_q;
	logic [TOT_W-1:0]   total_q;
	logic [PEND_W-1:0]  plen_q;
	logic [15:0]        prm0_q, prm1_q;
	logic [1:0]         slot_q;
	logic               full_q;
	logic [15:0]        row_q, col_q;
	logic               hit_q;
	logic [CLR_W-1:0]   clr_q;
	logic [LADDR_W-1:0] waddr_q;
	logic [COL_W-1:0]   wcol_q;
	logic [COL_W-1:0]   ncommit_q;
	logic               wr_v_s1, wr_use_s1;
	logic [COL_W-1:0]   wr_col_s1;
	logic               out_v_q;
	logic [7:0]         o_char_q, o_color_q;
	logic               o_mode_q;
	logic [15:0]        o_row_q, o_col_q;
	logic [7:0]         o_used_q, o_attr_q, o_pend_q;

	// config port
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = {24'd0, (paddr[2] == REG_CLEAR_COLOR) ? clrc_q : dflt_q};

	// accepted item decode
	logic       acc;
	logic [7:0] c;
	logic       is_byte, printable, pend_wr, scr_wr;
	logic [15:0] scr_row;
	state_t     acc_next;
	assign req_ch.ready = (state_q == ST_IDLE);
	assign acc       = req_ch.valid && req_ch.ready;
	assign c         = req_ch.char_code;
	assign is_byte   = acc && req_ch.req_type == REQ_BYTE && phase_q == PH_TEXT && c != CH_ESC;
	assign printable = c >= CH_SP && c != CH_DEL;
	assign pend_wr   = is_byte && !full_q && printable && plen_q < PEND_W'(PENDING_MAX - 1);
	assign scr_row   = (row_q >= 16'(SCR_ROWS)) ? 16'(SCR_ROWS - 1) : row_q;
	assign scr_wr    = is_byte && full_q && printable && col_q < 16'(LINE_COLS);

	// state taken when an item is accepted
	always_comb begin
		acc_next = ST_DONE;
		case (req_ch.req_type)
			REQ_BYTE: begin
				if (phase_q == PH_CSI) begin
					if ((c == CH_UH || c == CH_LF_F) && !full_q) acc_next = ST_CLEAR;
					else if (c == CH_UJ && !(prm0_q == 16'd3 && !full_q)) acc_next = ST_CLEAR;
					else if (c == CH_UK && full_q && row_q < 16'(SCR_ROWS)
						&& col_q < 16'(LINE_COLS)) acc_next = ST_ERASE;
				end else if (phase_q == PH_TEXT && c == CH_LF && !full_q && plen_q != '0) begin
					acc_next = ST_COMMIT;
				end
			end
			REQ_FLUSH: begin
				if (plen_q != '0 && !full_q) acc_next = ST_COMMIT;
			end
			REQ_READ: acc_next = ST_READ;
			default: acc_next = ST_DONE;
		endcase
	end

	// csi helpers
	logic [19:0] digit_v;
	logic [15:0] digit_sat;
	logic [7:0]  sgr_one, sgr_two;
	assign digit_v   = 20'((slot_q != 2'd0) ? prm1_q : prm0_q) * 20'd10 + 20'(c - CH_0);
	assign digit_sat = (digit_v > 20'(NUM_MAX)) ? NUM_MAX : digit_v[15:0];
	assign sgr_one   = sgr_apply(attr_q, prm0_q, dflt_q);
	assign sgr_two   = sgr_apply(sgr_one, prm1_q, dflt_q);

	// commit target line
	logic [ROW_W-1:0] cm_base;
	logic [TOT_W-1:0] cm_total;
	logic [ROW_W-1:0] cm_line;
	always_comb begin
		cm_base  = base_q;
		cm_total = total_q;
		if (total_q >= TOT_W'(STORE_LINES)) begin
			cm_base  = phys_line(base_q, ROW_W'(1));
			cm_total = TOT_W'(STORE_LINES - 1);
		end
		cm_line = phys_line(cm_base, ROW_W'(cm_total));
	end

	// memories
	logic               lwe, lre;
	logic [LADDR_W-1:0] lwaddr, lraddr;
	logic [CELL_W-1:0]  lwdata, lrdata, prdata_m;
	logic               pre;

	always_comb begin
		lwe    = 1'b0;
		lwaddr = waddr_q;
		lwdata = {CH_SP, attr_q};
		unique case (state_q)
			ST_CLEAR: begin
				lwe    = 1'b1;
				lwaddr = LADDR_W'(clr_q);
				lwdata = {CH_SP, clrc_q};
			end
			ST_ERASE: begin
				lwe = 1'b1;
			end
			ST_COMMIT: begin
				lwe    = wr_v_s1;
				lwaddr = waddr_q + LADDR_W'(wr_col_s1);
				lwdata = wr_use_s1 ? prdata_m : {CH_SP, dflt_q};
			end
			ST_IDLE: begin
				lwe    = scr_wr;
				lwaddr = line_addr(phys_line(base_q, ROW_W'(scr_row)), COL_W'(col_q));
				lwdata = {c, attr_q};
			end
			default: lwe = 1'b0;
		endcase
	end

	assign lre    = acc && req_ch.req_type == REQ_READ;
	assign lraddr = line_addr(phys_line(base_q, ROW_W'(req_ch.read_row)), COL_W'(req_ch.read_col));
	assign pre    = (state_q == ST_COMMIT) && wcol_q < COL_W'(LINE_COLS);

	ate_ram #(.WIDTH(CELL_W), .DEPTH(LDEPTH)) u_lines (
		.clk(clk), .we(lwe), .waddr(lwaddr), .wdata(lwdata),
		.re(lre), .raddr(lraddr), .rdata(lrdata)
	);

	ate_ram #(.WIDTH(CELL_W), .DEPTH(PENDING_MAX)) u_pending (
		.clk(clk), .we(pend_wr), .waddr(plen_q), .wdata({c, attr_q}),
		.re(pre), .raddr(PEND_W'(wcol_q)), .rdata(prdata_m)
	);

	// control, parser and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_TEXT;
			dflt_q    <= 8'd7;
			clrc_q    <= 8'd7;
			attr_q    <= 8'd7;
			base_q    <= '0;
			total_q   <= '0;
			plen_q    <= '0;
			prm0_q    <= '0;
			prm1_q    <= '0;
			slot_q    <= '0;
			full_q    <= 1'b0;
			row_q     <= '0;
			col_q     <= '0;
			hit_q     <= 1'b0;
			clr_q     <= '0;
			waddr_q   <= '0;
			wcol_q    <= '0;
			ncommit_q <= '0;
			wr_v_s1   <= 1'b0;
			wr_use_s1 <= 1'b0;
			wr_col_s1 <= '0;
			out_v_q   <= 1'b0;
			o_char_q  <= '0;
			o_color_q <= '0;
			o_mode_q  <= 1'b0;
			o_row_q   <= '0;
			o_col_q   <= '0;
			o_used_q  <= '0;
			o_attr_q  <= '0;
			o_pend_q  <= '0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_CLEAR_COLOR) clrc_q <= pwdata[7:0];
				else dflt_q <= pwdata[7:0];
			end
			if (rsp_ch.ready && state_q != ST_DONE) out_v_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						hit_q   <= req_ch.req_type == REQ_READ
							&& TOT_W'(req_ch.read_row) < total_q
							&& req_ch.read_col < 7'(LINE_COLS);
						state_q <= acc_next;
						case (req_ch.req_type)
							REQ_BYTE: begin
								if (phase_q == PH_ESC) begin
									if (c == CH_LBRK) begin
										phase_q <= PH_CSI;
										prm0_q  <= '0;
										prm1_q  <= '0;
										slot_q  <= '0;
									end else begin
										phase_q <= PH_TEXT;
									end
								end else if (phase_q == PH_CSI) begin
									if (c >= CH_0 && c <= CH_9) begin
										if (slot_q != 2'd0) prm1_q <= digit_sat;
										else prm0_q <= digit_sat;
									end else if (c == CH_SEMI) begin
										if (slot_q != 2'd2) slot_q <= slot_q + 2'd1;
									end else begin
										phase_q <= PH_TEXT;
										if (c == CH_UH || c == CH_LF_F) begin
											if (!full_q) begin
												base_q  <= '0;
												total_q <= TOT_W'(SCR_ROWS);
												full_q  <= 1'b1;
												clr_q   <= '0;
											end
											row_q <= (prm0_q != 16'd0) ? prm0_q - 16'd1 : 16'd0;
											col_q <= (prm1_q != 16'd0) ? prm1_q - 16'd1 : 16'd0;
										end else if (c == CH_UJ) begin
											if (prm0_q == 16'd3 && !full_q) begin
												total_q <= '0;
												base_q  <= '0;
											end else begin
												base_q  <= '0;
												total_q <= TOT_W'(SCR_ROWS);
												full_q  <= 1'b1;
												row_q   <= '0;
												col_q   <= '0;
												clr_q   <= '0;
											end
										end else if (c == CH_UK) begin
											if (full_q && row_q < 16'(SCR_ROWS)
												&& col_q < 16'(LINE_COLS)) begin
												waddr_q <= line_addr(phys_line(base_q, ROW_W'(row_q)),
													COL_W'(col_q));
												wcol_q  <= COL_W'(col_q);
											end
										end else if (c == CH_LM) begin
											attr_q <= (slot_q == 2'd0) ? sgr_one : sgr_two;
										end
									end
								end else if (c == CH_ESC) begin
									phase_q <= PH_ESC;
								end else if (full_q) begin
									if (c == CH_LF) begin
										if (row_q != NUM_MAX) row_q <= row_q + 16'd1;
										col_q <= '0;
									end else if (c == CH_CR) begin
										col_q <= '0;
									end else if (c == CH_BS || c == CH_DEL) begin
										if (col_q != 16'd0) col_q <= col_q - 16'd1;
									end else if (c >= CH_SP) begin
										row_q <= scr_row;
										if (scr_wr) col_q <= col_q + 16'd1;
									end
								end else begin
									if (c == CH_LF) begin
										if (plen_q != '0) begin
											base_q    <= cm_base;
											total_q   <= cm_total + TOT_W'(1);
											waddr_q   <= line_addr(cm_line, '0);
											ncommit_q <= (plen_q > PEND_W'(LINE_COLS - 1)) ?
												COL_W'(LINE_COLS - 1) : COL_W'(plen_q);
											wcol_q    <= '0;
											wr_v_s1   <= 1'b0;
										end
										plen_q <= '0;
									end else if (c == CH_BS || c == CH_DEL) begin
										if (plen_q != '0) plen_q <= plen_q - PEND_W'(1);
									end else if (c == CH_CR) begin
										plen_q <= '0;
									end else if (pend_wr) begin
										plen_q <= plen_q + PEND_W'(1);
									end
								end
							end
							REQ_FLUSH: begin
								if (plen_q != '0 && !full_q) begin
									base_q    <= cm_base;
									total_q   <= cm_total + TOT_W'(1);
									waddr_q   <= line_addr(cm_line, '0);
									ncommit_q <= (plen_q > PEND_W'(LINE_COLS - 1)) ?
										COL_W'(LINE_COLS - 1) : COL_W'(plen_q);
									wcol_q    <= '0;
									wr_v_s1   <= 1'b0;
								end
								plen_q  <= '0;
								phase_q <= PH_TEXT;
								attr_q  <= dflt_q;
								if (full_q) begin
									full_q  <= 1'b0;
									total_q <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_COMMIT: begin
					if (wcol_q < COL_W'(LINE_COLS)) begin
						wr_v_s1   <= 1'b1;
						wr_col_s1 <= wcol_q;
						wr_use_s1 <= wcol_q < ncommit_q;
						wcol_q    <= wcol_q + COL_W'(1);
					end else begin
						wr_v_s1 <= 1'b0;
						if (wr_v_s1) state_q <= ST_DONE;
					end
				end
				ST_CLEAR: begin
					if (clr_q == CLR_W'(CLR_CELLS - 1)) state_q <= ST_DONE;
					clr_q <= clr_q + CLR_W'(1);
				end
				ST_ERASE: begin
					if (wcol_q == COL_W'(LINE_COLS - 1)) state_q <= ST_DONE;
					wcol_q  <= wcol_q + COL_W'(1);
					waddr_q <= waddr_q + LADDR_W'(1);
				end
				ST_DONE: begin
					if (!out_v_q || rsp_ch.ready) begin
						out_v_q   <= 1'b1;
						o_char_q  <= hit_q ? lrdata[15:8] : 8'd0;
						o_color_q <= hit_q ? lrdata[7:0] : 8'd0;
						o_mode_q  <= full_q;
						o_row_q   <= row_q;
						o_col_q   <= col_q;
						o_used_q  <= 8'(total_q);
						o_attr_q  <= attr_q;
						o_pend_q  <= 8'(plen_q);
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result port
	assign rsp_ch.valid         = out_v_q;
	assign rsp_ch.cell_char     = o_char_q;
	assign rsp_ch.cell_color    = o_color_q;
	assign rsp_ch.screen_on     = o_mode_q;
	assign rsp_ch.cursor_row    = o_row_q;
	assign rsp_ch.cursor_col    = o_col_q;
	assign rsp_ch.lines_used    = o_used_q;
	assign rsp_ch.text_color    = o_attr_q;
	assign rsp_ch.pending_count = o_pend_q;
endmodule

// ----- test/tb_ansi_terminal_text_engine.sv -----
module tb_ansi_terminal_text_engine;
	import ate_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_NOP = 2'd3;
	localparam int LIMIT_CYCLES = 10000000;
	localparam int CLEAR_WAIT = SCR_ROWS * LINE_COLS + 100;
	localparam logic [2:0] VGA_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

	typedef struct {
		logic [7:0]  ch;
		logic [7:0]  color;
		logic        mode;
		logic [15:0] crow;
		logic [15:0] ccol;
		logic [7:0]  used;
		logic [7:0]  attr;
		logic [7:0]  pend;
	} term_view_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	ate_req_if req_ch();
	ate_rsp_if rsp_ch();

	ansi_terminal_text_engine DUT (
		.clk(clk), .arst_n(arst_n), .req_ch(req_ch), .rsp_ch(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #4 clk = ~clk;

	term_view_t view_q[$];
	int errors = 0;
	int cycles = 0;
	bit calm = 0;
	int stall_left = 0;

	// terminal model state
	logic [7:0]  m_chars [LDEPTH];
	logic [7:0]  m_attrs [LDEPTH];
	logic [7:0]  p_chars [PENDING_MAX];
	logic [7:0]  p_attrs [PENDING_MAX];
	int unsigned m_base, m_total, p_len, esc_ph, slot, cur_row, cur_col;
	int unsigned prm [2];
	logic [7:0]  attr_now, dflt_color, clr_color;
	bit          scr;

	function automatic int unsigned line_of(int unsigned lg);
		return (m_base + lg) % STORE_LINES;
	endfunction

	// push the pending line into the ring
	function automatic void commit_pending();
		int unsigned b, n;
		if (m_total >= STORE_LINES) begin
			m_base = (m_base + 1) % STORE_LINES;
			m_total = STORE_LINES - 1;
		end
		b = line_of(m_total) * LINE_COLS;
		for (int i = 0; i < LINE_COLS; i++) begin
			m_chars[b + i] = CH_SP;
			m_attrs[b + i] = dflt_color;
		end
		n = (p_len > LINE_COLS - 1) ? LINE_COLS - 1 : p_len;
		for (int i = 0; i < n; i++) begin
			m_chars[b + i] = p_chars[i];
			m_attrs[b + i] = p_attrs[i];
		end
		m_total++;
	endfunction

	function automatic void clear_screen();
		m_base = 0;
		for (int i = 0; i < SCR_ROWS * LINE_COLS; i++) begin
			m_chars[i] = CH_SP;
			m_attrs[i] = clr_color;
		end
		m_total = SCR_ROWS;
		cur_row = 0;
		cur_col = 0;
		scr = 1;
	endfunction

	function automatic void color_code(int unsigned v);
		if (v == 0) attr_now = dflt_color;
		else if (v == 1) attr_now = attr_now | 8'h08;
		else if (v == 7) attr_now = {attr_now[3:0], attr_now[7:4]};
		else if (v >= 30 && v <= 37) attr_now = {attr_now[7:4], 1'b0, VGA_MAP[v - 30]};
		else if (v >= 90 && v <= 97) attr_now = {attr_now[7:4], 1'b1, VGA_MAP[v - 90]};
		else if (v >= 40 && v <= 47) attr_now = {1'b0, VGA_MAP[v - 40], attr_now[3:0]};
		else if (v >= 100 && v <= 107) attr_now = {1'b1, VGA_MAP[v - 100], attr_now[3:0]};
	endfunction

	// one byte inside a control sequence
	function automatic void csi_char(logic [7:0] c);
		int unsigned i, v, b;
		if (c >= CH_0 && c <= CH_9) begin
			i = (slot < 1) ? slot : 1;
			v = prm[i] * 10 + (c - CH_0);
			prm[i] = (v > 65535) ? 65535 : v;
			return;
		end
		if (c == CH_SEMI) begin
			if (slot < 2) slot++;
			return;
		end
		if (c == CH_UH || c == CH_LF_F) begin
			if (!scr) clear_screen();
			cur_row = (prm[0] > 0) ? prm[0] - 1 : 0;
			cur_col = (prm[1] > 0) ? prm[1] - 1 : 0;
		end else if (c == CH_UJ) begin
			if (prm[0] == 3 && !scr) begin
				m_total = 0;
				m_base = 0;
			end else begin
				clear_screen();
			end
		end else if (c == CH_UK) begin
			if (scr && cur_row < SCR_ROWS) begin
				b = line_of(cur_row) * LINE_COLS;
				for (int x = cur_col; x < LINE_COLS; x++) begin
					m_chars[b + x] = CH_SP;
					m_attrs[b + x] = attr_now;
				end
			end
		end else if (c == CH_LM) begin
			for (int k = 0; k < slot + 1 && k < 2; k++) color_code(prm[k]);
		end
		esc_ph = 0;
	endfunction

	function automatic void out_char(logic [7:0] c);
		int unsigned at;
		if (esc_ph == 1) begin
			if (c == CH_LBRK) begin
				esc_ph = 2;
				prm[0] = 0;
				prm[1] = 0;
				slot = 0;
			end else begin
				esc_ph = 0;
			end
			return;
		end
		if (esc_ph >= 2) begin
			csi_char(c);
			return;
		end
		if (c == CH_ESC) begin
			esc_ph = 1;
			return;
		end
		// cursor addressed screen
		if (scr) begin
			if (c == CH_LF) begin
				if (cur_row < 65535) cur_row++;
				cur_col = 0;
			end else if (c == CH_CR) begin
				cur_col = 0;
			end else if (c == CH_BS || c == CH_DEL) begin
				if (cur_col > 0) cur_col--;
			end else if (c >= CH_SP) begin
				if (cur_row >= SCR_ROWS) cur_row = SCR_ROWS - 1;
				if (cur_col < LINE_COLS) begin
					at = line_of(cur_row) * LINE_COLS + cur_col;
					m_chars[at] = c;
					m_attrs[at] = attr_now;
					cur_col++;
				end
			end
			return;
		end
		// scrollback line editing
		if (c == CH_LF) begin
			if (p_len > 0) commit_pending();
			p_len = 0;
		end else if (c == CH_BS || c == CH_DEL) begin
			if (p_len > 0) p_len--;
		end else if (c == CH_CR) begin
			p_len = 0;
		end else if (c >= CH_SP && p_len < PENDING_MAX - 1) begin
			p_attrs[p_len] = attr_now;
			p_chars[p_len] = c;
			p_len++;
		end
	endfunction

	function automatic term_view_t terminal_after(logic [1:0] kind, logic [7:0] code,
		logic [6:0] row, logic [6:0] col);
		term_view_t w;
		int unsigned at;
		w.ch = 8'd0;
		w.color = 8'd0;
		if (kind == REQ_BYTE) begin
			out_char(code);
		end else if (kind == REQ_FLUSH) begin
			if (p_len > 0 && !scr) commit_pending();
			p_len = 0;
			esc_ph = 0;
			attr_now = dflt_color;
			if (scr) begin
				scr = 0;
				m_total = 0;
			end
		end else if (kind == REQ_READ) begin
			if (row < m_total && col < LINE_COLS) begin
				at = line_of(row) * LINE_COLS + col;
				w.ch = m_chars[at];
				w.color = m_attrs[at];
			end
		end
		w.mode = scr;
		w.crow = cur_row[15:0];
		w.ccol = cur_col[15:0];
		w.used = m_total[7:0];
		w.attr = attr_now;
		w.pend = p_len[7:0];
		return w;
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver stalls in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 8);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	task automatic report_mismatch(string field, int got, int want);
		if (got != want) begin
			$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
			errors++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		term_view_t w;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (view_q.size() == 0) begin
				$display("unexpected result item at %0t", $realtime);
				errors++;
			end else begin
				w = view_q.pop_front();
				report_mismatch("cell_char", rsp_ch.cell_char, w.ch);
				report_mismatch("cell_color", rsp_ch.cell_color, w.color);
				report_mismatch("screen_on", rsp_ch.screen_on, w.mode);
				report_mismatch("cursor_row", rsp_ch.cursor_row, w.crow);
				report_mismatch("cursor_col", rsp_ch.cursor_col, w.ccol);
				report_mismatch("lines_used", rsp_ch.lines_used, w.used);
				report_mismatch("text_color", rsp_ch.text_color, w.attr);
				report_mismatch("pending_count", rsp_ch.pending_count, w.pend);
			end
		end
	end

	task automatic send_item(logic [1:0] kind, logic [7:0] code, logic [6:0] row,
		logic [6:0] col);
		if (!calm && $urandom_range(0, 6) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.char_code <= code;
		req_ch.read_row <= row;
		req_ch.read_col <= col;
		do @(posedge clk); while (!req_ch.ready);
		view_q.push_back(terminal_after(kind, code, row, col));
	endtask

	task automatic put_byte(logic [7:0] c);
		send_item(REQ_BYTE, c, 7'($urandom), 7'($urandom));
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i]);
	endtask

	task automatic put_csi(string body);
		put_byte(CH_ESC);
		put_byte(CH_LBRK);
		put_text(body);
	endtask

	task automatic read_cell(int row, int col);
		send_item(REQ_READ, 8'($urandom), 7'(row), 7'(col));
	endtask

	task automatic flush();
		send_item(REQ_FLUSH, 8'($urandom), 7'($urandom), 7'($urandom));
	endtask

	// drain all results and let any long clear finish
	task automatic settle();
		req_ch.valid <= 1'b0;
		wait (view_q.size() == 0);
		repeat (CLEAR_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_DEFAULT_COLOR) dflt_color = val;
		else clr_color = val;
	endtask

	function automatic int pick_color_code();
		case ($urandom_range(0, 6))
			0: return 0;
			1: return 1;
			2: return 7;
			3: return $urandom_range(30, 37);
			4: return $urandom_range(90, 97);
			5: return ($urandom_range(0, 1)) ? $urandom_range(40, 47) : $urandom_range(100, 107);
			default: return $urandom_range(0, 200);
		endcase
	endfunction

	task automatic test_scrollback_basics();
		read_cell(0, 0);
		send_item(REQ_NOP, 8'hFF, 7'h7F, 7'h7F);
		put_text("Ab");
		put_byte(CH_BS);
		put_byte(CH_DEL);
		put_byte(8'h01);
		put_byte(8'hFF);
		put_byte(CH_CR);
		put_byte(CH_ESC);
		put_byte(8'h41);
		put_csi($sformatf("1;31%c", CH_LM));
		put_byte(8'h80);
		put_csi($sformatf("99999999;1;7%c", CH_LM));
		put_byte(CH_LF);
		read_cell(0, 0);
		read_cell(0, 79);
		read_cell(0, 127);
		read_cell(127, 0);
		flush();
	endtask

	task automatic test_screen_mode();
		put_csi($sformatf("65535;65535%c", CH_UH));
		put_byte(CH_LF);
		put_byte(CH_LF);
		put_byte(8'h7E);
		put_csi($sformatf("%c", CH_UK));
		put_csi($sformatf("3;70%c", CH_LF_F));
		put_text("xy");
		put_byte(CH_BS);
		put_csi($sformatf("97;104%c", CH_LM));
		put_csi($sformatf("%c", CH_UK));
		read_cell(2, 68);
		read_cell(2, 75);
		put_csi($sformatf("3%c", CH_UJ));
		flush();
	endtask

	task automatic test_long_line();
		for (int i = 0; i < PENDING_MAX + 4; i++) put_byte(8'($urandom_range(32, 255)));
		put_byte(CH_LF);
		read_cell(0, $urandom_range(0, 79));
		put_csi($sformatf("3%c", CH_UJ));
		put_text("z");
		flush();
	endtask

	task automatic test_ring_wrap();
		for (int i = 0; i < STORE_LINES + 6; i++) begin
			put_byte(8'($urandom_range(32, 126)));
			put_byte(CH_LF);
		end
		for (int i = 0; i < 8; i++) read_cell($urandom_range(0, 127), $urandom_range(0, 2));
	endtask

	task automatic test_random(int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 40) put_byte(8'($urandom_range(32, 255)));
			else if (r < 50) put_byte(CH_LF);
			else if (r < 54) put_byte(($urandom_range(0, 1)) ? CH_BS : CH_DEL);
			else if (r < 56) put_byte(CH_CR);
			else if (r < 58) put_byte(8'($urandom_range(0, 31)));
			else if (r < 68) begin
				if ($urandom_range(0, 1))
					put_csi($sformatf("%0d%c", pick_color_code(), CH_LM));
				else
					put_csi($sformatf("%0d;%0d%c", pick_color_code(), pick_color_code(), CH_LM));
			end else if (r < 71) begin
				put_csi($sformatf("%0d;%0d%c", $urandom_range(0, 30), $urandom_range(0, 90),
					($urandom_range(0, 1)) ? CH_UH : CH_LF_F));
			end else if (r < 73) put_csi($sformatf("%0d%c", $urandom_range(0, 3), CH_UJ));
			else if (r < 76) put_csi($sformatf("%c", CH_UK));
			else if (r < 78) begin
				put_byte(CH_ESC);
				put_byte(8'($urandom_range(0, 90)));
			end else if (r < 79) put_csi($sformatf("5%c", 8'h7A));
			else if (r < 93) begin
				read_cell($urandom_range(0, (m_total + 2 > 127) ? 127 : m_total + 2),
					($urandom_range(0, 9) == 0) ? $urandom_range(80, 127) : $urandom_range(0, 79));
			end else if (r < 97) flush();
			else send_item(REQ_NOP, 8'($urandom), 7'($urandom), 7'($urandom));
		end
	endtask

	task automatic test_color_settings();
		write_reg(REG_DEFAULT_COLOR, 8'h00);
		write_reg(REG_CLEAR_COLOR, 8'hFF);
		test_random(20);
		settle();
		write_reg(REG_DEFAULT_COLOR, 8'hFF);
		write_reg(REG_CLEAR_COLOR, 8'h00);
		flush();
		test_random(15);
		settle();
		write_reg(REG_DEFAULT_COLOR, 8'($urandom));
		write_reg(REG_CLEAR_COLOR, 8'($urandom));
	endtask

	initial begin
		m_base = 0; m_total = 0; p_len = 0; esc_ph = 0; slot = 0;
		cur_row = 0; cur_col = 0; prm[0] = 0; prm[1] = 0;
		dflt_color = 8'd7; clr_color = 8'd7; attr_now = 8'd7; scr = 0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		req_ch.valid = 1'b0; req_ch.req_type = REQ_BYTE; req_ch.char_code = '0;
		req_ch.read_row = '0; req_ch.read_col = '0;
		rsp_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_scrollback_basics();
		test_screen_mode();
		test_long_line();
		test_ring_wrap();
		test_random(20);
		req_ch.valid <= 1'b0;
		wait (view_q.size() == 0);
		@(posedge clk);
		test_random(20);
		settle();
		test_color_settings();
		calm = 1;
		test_random(25);
		req_ch.valid <= 1'b0;
		wait (view_q.size() == 0);
		repeat (CLEAR_WAIT) @(posedge clk);

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
